### src/mefr_pkg.sv
package mefr_pkg;

  // bits in one frame byte
  localparam int unsigned BitsPerByte = 8;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegShortLow  = 3'd0,
    RegShortHigh = 3'd1,
    RegLongLow   = 3'd2,
    RegLongHigh  = 3'd3,
    RegPreamble  = 3'd4
  } reg_idx_t;

  // result event codes
  typedef enum logic [2:0] {
    EvPayload    = 3'd0,
    EvFrameGood  = 3'd1,
    EvCheckBad   = 3'd2,
    EvTimingErr  = 3'd3,
    EvPreambleBad = 3'd4,
    EvUnknownType = 3'd5
  } event_t;

  // frame type bytes
  localparam logic [7:0] TypeText   = 8'd1;
  localparam logic [7:0] TypeBitmap = 8'd2;

  // configuration registers as seen by the decoder
  typedef struct packed {
    logic [15:0] short_low;
    logic [15:0] short_high;
    logic [15:0] long_low;
    logic [15:0] long_high;
    logic [7:0]  preamble_byte;
  } cfg_t;

  // what the line machine tells the frame parser for one edge
  typedef struct packed {
    logic clear;       // drop frame and bit buffer
    logic push;        // push bit without parsing
    logic feed;        // push bit and run the parser
    logic timing_err;  // bad interval outside idle
    logic bit_val;
  } line_ev_t;

  // one result item
  typedef struct packed {
    event_t     event_res;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_type;
    logic [7:0] size_first;
    logic [7:0] size_second;
  } result_t;

endpackage

### src/mefr_line.sv
module mefr_line (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [15:0]       interval,
  input  logic              line_level,
  input  mefr_pkg::cfg_t    cfg,
  input  logic              frame_finish,
  output mefr_pkg::line_ev_t ev
);
  import mefr_pkg::*;

  typedef enum logic [2:0] {
    LpIdle  = 3'd0,
    LpStart = 3'd1,
    LpAlt   = 3'd2,
    LpRep1  = 3'd3,
    LpRep2  = 3'd4
  } line_phase_t;

  line_phase_t line_phase, line_phase_next;
  logic        current_bit, current_bit_next;
  logic        is_short, is_long;

  // interval windows
  assign is_short = (interval >= cfg.short_low) && (interval <= cfg.short_high);
  assign is_long  = (interval >= cfg.long_low) && (interval <= cfg.long_high);

  // manchester decode of one classed interval
  always_comb begin
    ev               = '0;
    line_phase_next  = line_phase;
    current_bit_next = current_bit;
    case (line_phase)
      LpStart: begin
        if (is_short || !is_long) begin
          ev.timing_err = 1'b1;
        end else begin
          current_bit_next = ~current_bit;
          ev.push          = 1'b1;
          ev.bit_val       = ~current_bit;
          line_phase_next  = LpAlt;
        end
      end
      LpAlt: begin
        if (is_long) begin
          current_bit_next = ~current_bit;
          ev.feed          = 1'b1;
          ev.bit_val       = ~current_bit;
        end else if (is_short) begin
          line_phase_next = LpRep1;
        end else begin
          ev.timing_err = 1'b1;
        end
      end
      LpRep1: begin
        if (!is_short) begin
          ev.timing_err = 1'b1;
        end else begin
          ev.feed         = 1'b1;
          ev.bit_val      = current_bit;
          line_phase_next = LpRep2;
        end
      end
      LpRep2: begin
        if (is_short) begin
          line_phase_next = LpRep1;
        end else if (is_long) begin
          current_bit_next = ~current_bit;
          ev.feed          = 1'b1;
          ev.bit_val       = ~current_bit;
          line_phase_next  = LpAlt;
        end else begin
          ev.timing_err = 1'b1;
        end
      end
      default: begin
        // idle: noise and gaps clear silently, a long edge opens a frame
        ev.clear = 1'b1;
        if (!is_short && is_long) begin
          current_bit_next = line_level;
          ev.push          = 1'b1;
          ev.bit_val       = line_level;
          line_phase_next  = LpStart;
        end else begin
          line_phase_next = LpIdle;
        end
      end
    endcase
    if (ev.timing_err || frame_finish) begin
      line_phase_next = LpIdle;
    end
  end

  // phase and bit state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase  <= LpIdle;
      current_bit <= 1'b0;
    end else if (step) begin
      line_phase  <= line_phase_next;
      current_bit <= current_bit_next;
    end
  end

  a_err_excl: assert property (@(posedge clk) disable iff (rst)
    !(ev.timing_err && (ev.feed || ev.push)))
    else $error("timing error together with a bit");

  a_start_from_idle: assert property (@(posedge clk) disable iff (rst)
    (line_phase == LpStart && $past(line_phase) != LpStart)
      |-> $past(line_phase == LpIdle))
    else $error("start phase not entered from idle");

endmodule

### src/mefr_frame.sv
module mefr_frame (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  mefr_pkg::line_ev_t ev,
  input  logic [7:0]         preamble_byte,
  output logic               frame_finish,
  output logic               res_valid,
  output mefr_pkg::result_t  res
);
  import mefr_pkg::*;

  typedef enum logic [2:0] {
    FpPre   = 3'd0,
    FpType  = 3'd1,
    FpSize  = 3'd2,
    FpData  = 3'd3,
    FpCheck = 3'd4
  } frame_phase_t;

  frame_phase_t frame_phase, frame_phase_next;
  logic [7:0]   bit_shift, bit_shift_next;
  logic [3:0]   bit_count, bit_count_next;
  logic [8:0]   byte_count, byte_count_next;
  logic [7:0]   frame_kind, frame_kind_next;
  logic [7:0]   first_size, first_size_next;
  logic [7:0]   second_size, second_size_next;
  logic [7:0]   running_sum, running_sum_next;

  logic         byte_done;
  logic [7:0]   byte_val;
  logic [7:0]   idx;
  logic         do_clear;

  // bit packer, msb first, byte taken when its ninth bit shows up
  always_comb begin
    byte_done = (bit_count >= 4'(BitsPerByte));
    byte_val  = bit_shift;
  end

  assign idx = byte_count[7:0];

  // frame parser
  always_comb begin
    frame_phase_next = frame_phase;
    bit_shift_next   = bit_shift;
    bit_count_next   = bit_count;
    byte_count_next  = byte_count;
    frame_kind_next  = frame_kind;
    first_size_next  = first_size;
    second_size_next = second_size;
    running_sum_next = running_sum;
    do_clear         = 1'b0;
    frame_finish     = 1'b0;
    res_valid        = 1'b0;
    res.event_res    = EvPayload;
    res.data_byte    = '0;
    res.byte_index   = '0;
    res.frame_type   = frame_kind;
    res.size_first   = first_size;
    res.size_second  = second_size;

    if (ev.push || ev.feed) begin
      if (byte_done) begin
        bit_shift_next = {7'b0, ev.bit_val};
        bit_count_next = 4'd1;
      end else begin
        bit_shift_next = {bit_shift[6:0], ev.bit_val};
        bit_count_next = bit_count + 4'd1;
      end
    end

    if (ev.clear) begin
      do_clear = 1'b1;
    end else if (ev.timing_err) begin
      res_valid     = 1'b1;
      res.event_res = EvTimingErr;
      do_clear      = 1'b1;
    end else if (ev.feed) begin
      case (frame_phase)
        FpType: begin
          if (byte_done) begin
            frame_kind_next = byte_val;
            if (byte_val != TypeText && byte_val != TypeBitmap) begin
              res_valid      = 1'b1;
              res.event_res  = EvUnknownType;
              res.frame_type = byte_val;
              frame_finish   = 1'b1;
              do_clear       = 1'b1;
            end else begin
              frame_phase_next = FpSize;
              byte_count_next  = '0;
            end
          end
        end
        FpSize: begin
          if (byte_done) begin
            if (byte_count == '0) begin
              first_size_next  = byte_val;
              second_size_next = '0;
            end else begin
              second_size_next = byte_val;
            end
            if (byte_count == '0 && frame_kind == TypeBitmap) begin
              byte_count_next = 9'd1;
            end else begin
              frame_phase_next = FpData;
              byte_count_next  = '0;
              running_sum_next = '0;
            end
          end
        end
        FpData: begin
          if (byte_done) begin
            // payload adds, checksum subtracts
            if (idx < first_size) begin
              running_sum_next = running_sum + byte_val;
            end else begin
              running_sum_next = running_sum - byte_val;
              frame_phase_next = FpCheck;
            end
            byte_count_next = byte_count + 9'd1;
            res_valid       = 1'b1;
            res.data_byte   = byte_val;
            res.byte_index  = idx;
          end
        end
        FpCheck: begin
          res_valid     = 1'b1;
          res.event_res = (running_sum == '0) ? EvFrameGood : EvCheckBad;
          frame_finish  = 1'b1;
          do_clear      = 1'b1;
        end
        default: begin
          if (byte_done) begin
            if (byte_val != preamble_byte) begin
              res_valid     = 1'b1;
              res.event_res = EvPreambleBad;
              frame_finish  = 1'b1;
              do_clear      = 1'b1;
            end else begin
              frame_phase_next = FpType;
              byte_count_next  = '0;
            end
          end
        end
      endcase
    end

    // clear keeps a start bit pushed in the same edge
    if (do_clear) begin
      frame_phase_next = FpPre;
      byte_count_next  = '0;
      frame_kind_next  = '0;
      first_size_next  = '0;
      second_size_next = '0;
      running_sum_next = '0;
      if (ev.clear && ev.push) begin
        bit_shift_next = {7'b0, ev.bit_val};
        bit_count_next = 4'd1;
      end else begin
        bit_shift_next = '0;
        bit_count_next = '0;
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase <= FpPre;
      bit_shift   <= '0;
      bit_count   <= '0;
      byte_count  <= '0;
      frame_kind  <= '0;
      first_size  <= '0;
      second_size <= '0;
      running_sum <= '0;
    end else if (step) begin
      frame_phase <= frame_phase_next;
      bit_shift   <= bit_shift_next;
      bit_count   <= bit_count_next;
      byte_count  <= byte_count_next;
      frame_kind  <= frame_kind_next;
      first_size  <= first_size_next;
      second_size <= second_size_next;
      running_sum <= running_sum_next;
    end
  end

  a_bit_count: assert property (@(posedge clk) disable iff (rst)
    bit_count <= 4'(BitsPerByte))
    else $error("bit count beyond one byte");

  a_payload_bound: assert property (@(posedge clk) disable iff (rst)
    (frame_phase == FpData) |-> (byte_count <= {1'b0, first_size}))
    else $error("payload index past checksum position");

endmodule

### src/manchester_edge_frame_receiver.sv
// Manchester edge frame receiver. Each transfer on the slave side is one line
// edge (ticks since the previous edge and the new line level); an edge is
// taken every clock cycle unless the result side stalls, and its result, if
// any, appears on the master side through the input register, then the
// result register. The interval compares and line and frame state update are
// combinational between them, setting the rate at one edge per unstalled cycle.
// An edge yields at most one result: a payload or checksum byte (event 0) or
// a verdict (1 frame good, 2 checksum bad, 3 timing error, 4 preamble bad,
// 5 unknown type). Configuration writes are taken at any time with ready
// held high, but should be made only while no edge is in flight.
module manchester_edge_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  // edge input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // interval[15:0], line_level[16], zero pad
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // data_byte, byte_index, frame_type,
                                 // size_first, size_second
  output logic [2:0]  m_tuser,   // event_res
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mefr_pkg::*;

  cfg_t              cfg;
  logic              in_valid;
  logic [15:0]       in_interval;
  logic              in_level;
  logic              fire;
  line_ev_t          ev;
  logic              frame_finish;
  logic              res_valid;
  result_t           res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_low     <= 16'd750;
      cfg.short_high    <= 16'd1250;
      cfg.long_low      <= 16'd1750;
      cfg.long_high     <= 16'd2250;
      cfg.preamble_byte <= 8'd170;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegShortLow:  cfg.short_low     <= cfg_data;
        RegShortHigh: cfg.short_high    <= cfg_data;
        RegLongLow:   cfg.long_low      <= cfg_data;
        RegLongHigh:  cfg.long_high     <= cfg_data;
        RegPreamble:  cfg.preamble_byte <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // process the held edge when the result slot is free or draining
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_interval <= s_tdata[15:0];
      in_level    <= s_tdata[16];
    end
  end

  mefr_line u_line (
    .clk          (clk),
    .rst          (rst),
    .step         (fire),
    .interval     (in_interval),
    .line_level   (in_level),
    .cfg          (cfg),
    .frame_finish (frame_finish),
    .ev           (ev)
  );

  mefr_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .step          (fire),
    .ev            (ev),
    .preamble_byte (cfg.preamble_byte),
    .frame_finish  (frame_finish),
    .res_valid     (res_valid),
    .res           (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      m_tuser <= res.event_res;
      m_tdata <= {res.size_second, res.size_first, res.frame_type,
                  res.byte_index, res.data_byte};
    end
  end

  a_verdict_no_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != EvPayload) |-> (m_tdata[15:0] == 16'd0))
    else $error("verdict carries a data byte or index");

endmodule

### bench/tb.sv
// line and frame phases of the decoder as the scoreboard tracks them
typedef enum logic [2:0] {LnIdle, LnStart, LnAlt, LnRep1, LnRep2} line_phase_t;
typedef enum logic [2:0] {FrPreamble, FrType, FrSize, FrData, FrCheck} frame_phase_t;

class edge_scoreboard;
  // register copies
  logic [15:0] short_lo = 16'd750;
  logic [15:0] short_hi = 16'd1250;
  logic [15:0] long_lo = 16'd1750;
  logic [15:0] long_hi = 16'd2250;
  logic [7:0] preamble = 8'hAA;

  // decoder state
  line_phase_t line_st = LnIdle;
  frame_phase_t frame_st = FrPreamble;
  bit cur_bit = 1'b0;
  logic [7:0] shift_reg = 8'd0;
  logic [3:0] bit_cnt = 4'd0;
  logic [8:0] byte_cnt = 9'd0;
  logic [7:0] kind = 8'd0;
  logic [7:0] size_a = 8'd0;
  logic [7:0] size_b = 8'd0;
  logic [7:0] sum = 8'd0;

  mefr_pkg::result_t frame_results_due[$];
  int errors = 0;
  string field_name[5] = '{"data_byte", "byte_index", "frame_type", "size_first",
                           "size_second"};

  function void set_reg(mefr_pkg::reg_idx_t idx, logic [15:0] val);
    case (idx)
      mefr_pkg::RegShortLow: short_lo = val;
      mefr_pkg::RegShortHigh: short_hi = val;
      mefr_pkg::RegLongLow: long_lo = val;
      mefr_pkg::RegLongHigh: long_hi = val;
      mefr_pkg::RegPreamble: preamble = val[7:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return frame_results_due.size();
  endfunction

  // drop the frame and the bit buffer, the current bit stays
  function void clear_frame();
    frame_st = FrPreamble;
    shift_reg = 8'd0;
    bit_cnt = 4'd0;
    byte_cnt = 9'd0;
    kind = 8'd0;
    size_a = 8'd0;
    size_b = 8'd0;
    sum = 8'd0;
  endfunction

  function void emit(mefr_pkg::event_t ev, logic [7:0] val, logic [7:0] idx);
    mefr_pkg::result_t r;
    r.event_res = ev;
    r.data_byte = val;
    r.byte_index = idx;
    r.frame_type = kind;
    r.size_first = size_a;
    r.size_second = size_b;
    frame_results_due.push_back(r);
  endfunction

  function void verdict(mefr_pkg::event_t ev);
    emit(ev, 8'd0, 8'd0);
    clear_frame();
    line_st = LnIdle;
  endfunction

  // msb first; a byte is done when the ninth bit arrives
  function bit push_bit(bit b, output logic [7:0] done_val);
    done_val = 8'd0;
    if (bit_cnt >= 4'd8) begin
      done_val = shift_reg;
      shift_reg = {7'd0, b};
      bit_cnt = 4'd1;
      return 1'b1;
    end
    shift_reg = {shift_reg[6:0], b};
    bit_cnt = bit_cnt + 4'd1;
    return 1'b0;
  endfunction

  // decoded bit into the frame parser
  function void parse_bit(bit b);
    logic [7:0] val;
    logic [7:0] idx;
    bit done;
    done = push_bit(b, val);
    case (frame_st)
      FrType: begin
        if (!done) return;
        kind = val;
        if (val != mefr_pkg::TypeText && val != mefr_pkg::TypeBitmap) begin
          verdict(mefr_pkg::EvUnknownType);
        end else begin
          frame_st = FrSize;
          byte_cnt = 9'd0;
        end
      end
      FrSize: begin
        if (!done) return;
        if (byte_cnt == 9'd0) begin
          size_a = val;
          size_b = 8'd0;
          if (kind == mefr_pkg::TypeBitmap) begin
            byte_cnt = 9'd1;
            return;
          end
        end else begin
          size_b = val;
        end
        frame_st = FrData;
        byte_cnt = 9'd0;
        sum = 8'd0;
      end
      FrData: begin
        if (!done) return;
        idx = byte_cnt[7:0];
        if (idx < size_a) sum = sum + val;
        else sum = sum - val;
        byte_cnt = byte_cnt + 9'd1;
        emit(mefr_pkg::EvPayload, val, idx);
        if (idx >= size_a) frame_st = FrCheck;
      end
      FrCheck: begin
        verdict(sum == 8'd0 ? mefr_pkg::EvFrameGood : mefr_pkg::EvCheckBad);
      end
      default: begin
        if (!done) return;
        if (val != preamble) begin
          verdict(mefr_pkg::EvPreambleBad);
        end else begin
          frame_st = FrType;
          byte_cnt = 9'd0;
        end
      end
    endcase
  endfunction

  // one accepted edge through the manchester machine
  function void note_edge(logic [15:0] iv, bit lvl);
    logic [7:0] spare;
    bit is_short;
    bit is_long;
    is_short = iv >= short_lo && iv <= short_hi;
    is_long = iv >= long_lo && iv <= long_hi;
    case (line_st)
      LnStart: begin
        if (is_short || !is_long) begin
          verdict(mefr_pkg::EvTimingErr);
        end else begin
          cur_bit = ~cur_bit;
          void'(push_bit(cur_bit, spare));
          line_st = LnAlt;
        end
      end
      LnAlt: begin
        if (is_long) begin
          cur_bit = ~cur_bit;
          line_st = LnAlt;
          parse_bit(cur_bit);
        end else if (is_short) begin
          line_st = LnRep1;
        end else begin
          verdict(mefr_pkg::EvTimingErr);
        end
      end
      LnRep1: begin
        if (!is_short) begin
          verdict(mefr_pkg::EvTimingErr);
        end else begin
          line_st = LnRep2;
          parse_bit(cur_bit);
        end
      end
      LnRep2: begin
        if (is_short) begin
          line_st = LnRep1;
        end else if (is_long) begin
          cur_bit = ~cur_bit;
          line_st = LnAlt;
          parse_bit(cur_bit);
        end else begin
          verdict(mefr_pkg::EvTimingErr);
        end
      end
      default: begin
        clear_frame();
        if (!is_short && is_long) begin
          cur_bit = lvl;
          void'(push_bit(cur_bit, spare));
          line_st = LnStart;
        end else begin
          line_st = LnIdle;
        end
      end
    endcase
  endfunction

  task report(string what, int got, int want);
    $display("mismatch: %s is %0d, expected %0d", what, got, want);
    errors++;
  endtask

  task check_result(logic [2:0] ev, logic [39:0] data);
    mefr_pkg::result_t want;
    logic [39:0] want_data;
    if (frame_results_due.size() == 0) begin
      report("result with nothing expected, event_res", ev, 0);
      return;
    end
    want = frame_results_due.pop_front();
    want_data = {want.size_second, want.size_first, want.frame_type, want.byte_index,
                 want.data_byte};
    if (ev !== want.event_res) report("event_res", ev, want.event_res);
    for (int k = 0; k < 5; k++) begin
      if (data[8*k +: 8] !== want_data[8*k +: 8]) begin
        report(field_name[k], data[8*k +: 8], want_data[8*k +: 8]);
      end
    end
  endtask
endclass

module tb;
  import mefr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  // (line level, interval) pairs walking every line phase under reset windows
  localparam logic [16:0] DIRECTED_EDGES [27] = '{
    {1'b0, 16'd0},     {1'b1, 16'd65535}, {1'b0, 16'd1000},  {1'b1, 16'd2000},
    {1'b0, 16'd1000},  {1'b0, 16'd2000},  {1'b1, 16'd65535}, {1'b1, 16'd2000},
    {1'b0, 16'd2000},  {1'b1, 16'd1000},  {1'b0, 16'd2000},  {1'b0, 16'd2000},
    {1'b1, 16'd2000},  {1'b0, 16'd30000}, {1'b1, 16'd2000},  {1'b0, 16'd2000},
    {1'b1, 16'd1000},  {1'b0, 16'd1000},  {1'b1, 16'd1000},  {1'b0, 16'd1250},
    {1'b1, 16'd750},   {1'b0, 16'd2250},  {1'b1, 16'd1750},  {1'b0, 16'd1750},
    {1'b1, 16'd1000},  {1'b0, 16'd1000},  {1'b1, 16'd2251}
  };

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = 24'd0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;

  edge_scoreboard sb = new();
  bit calm = 1'b0;
  bit frame_bits[$];
  int frame_edges;
  int glitch_at;
  int edges_sent = 0;
  int unsigned cycles = 0;

  manchester_edge_frame_receiver u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, none while calm
  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function logic [15:0] pick_short();
    return 16'($urandom_range(sb.short_lo, sb.short_hi));
  endfunction

  function logic [15:0] pick_long();
    return 16'($urandom_range(sb.long_lo, sb.long_hi));
  endfunction

  // result side stalls
  initial begin
    int run;
    int stall;
    forever begin
      run = calm ? 20 : $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // result transfers
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  // one edge transfer, valid stays high for a following edge
  task send_edge(logic [15:0] iv, bit lvl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, lvl, iv};
    do @(posedge clk); while (!s_tready);
    sb.note_edge(iv, lvl);
    edges_sent++;
  endtask

  // edge of a frame, optionally replaced by a random interval
  task line_edge(logic [15:0] iv, bit lvl);
    if (frame_edges == glitch_at) send_edge(16'($urandom_range(0, 65535)), lvl);
    else send_edge(iv, lvl);
    frame_edges++;
  endtask

  task add_byte(logic [7:0] v);
    for (int j = 7; j >= 0; j--) frame_bits.push_back(v[j]);
  endtask

  // manchester line coding of frame_bits: toggle on long, repeat on two shorts
  task send_bits();
    bit cur;
    bit lvl;
    lvl = frame_bits[0];
    line_edge(pick_long(), lvl);
    cur = frame_bits[0];
    lvl = ~lvl;
    line_edge(pick_long(), lvl);
    cur = ~cur;
    for (int k = 2; k < frame_bits.size(); k++) begin
      if (frame_bits[k] != cur) begin
        lvl = ~lvl;
        line_edge(pick_long(), lvl);
        cur = frame_bits[k];
      end else begin
        repeat (2) begin
          lvl = ~lvl;
          line_edge(pick_short(), lvl);
        end
      end
    end
  endtask

  // line gap and idle noise, then a mostly well formed frame
  task random_frame(int force_size);
    logic [7:0] ftype;
    logic [7:0] fsize;
    logic [7:0] csum;
    logic [7:0] v;
    logic [15:0] iv;
    int noise;
    frame_bits.delete();
    frame_edges = 0;
    send_edge(16'hFFFF, 1'($urandom_range(0, 1)));
    noise = $urandom_range(0, 2);
    repeat (noise) begin
      iv = 16'($urandom_range(0, 65535));
      if (iv >= sb.long_lo && iv <= sb.long_hi) iv = 16'hFFFF;
      send_edge(iv, 1'($urandom_range(0, 1)));
    end
    add_byte(($urandom_range(0, 99) < 7) ? 8'($urandom) : sb.preamble);
    v = 8'($urandom_range(0, 99));
    if (v < 10) ftype = 8'($urandom);
    else if (v < 55) ftype = TypeText;
    else ftype = TypeBitmap;
    add_byte(ftype);
    if (force_size >= 0) fsize = 8'(force_size);
    else if ($urandom_range(0, 99) < 85) fsize = 8'($urandom_range(0, 6));
    else fsize = 8'($urandom_range(7, 20));
    add_byte(fsize);
    if (ftype == TypeBitmap) add_byte(8'($urandom));
    csum = 8'd0;
    for (int n = 0; n < fsize; n++) begin
      v = 8'($urandom);
      csum = csum + v;
      add_byte(v);
    end
    if ($urandom_range(0, 5) == 0) csum = csum ^ 8'($urandom_range(1, 255));
    add_byte(csum);
    // one bit closes the checksum byte, one more brings the verdict
    frame_bits.push_back(1'($urandom_range(0, 1)));
    frame_bits.push_back(1'($urandom_range(0, 1)));
    glitch_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, frame_bits.size()) : -1;
    send_bits();
  endtask

  task run_frames(int edge_goal);
    int start;
    start = edges_sent;
    while (edges_sent - start < edge_goal) begin
      calm = ($urandom_range(0, 5) == 0);
      random_frame(-1);
    end
    calm = 1'b0;
  endtask

  // stop sending and wait until every result is in and the pipe is empty
  task drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task load_config(int sl, int sh, int ll, int lh, logic [7:0] pre);
    drain();
    write_reg(RegShortLow, 16'(sl));
    write_reg(RegShortHigh, 16'(sh));
    write_reg(RegLongLow, 16'(ll));
    write_reg(RegLongHigh, 16'(lh));
    write_reg(RegPreamble, {8'd0, pre});
    cfg_valid <= 1'b0;
  endtask

  // random non overlapping windows, preamble with a valid start pair
  task random_config();
    int sl;
    int sh;
    int ll;
    int lh;
    logic [7:0] pre;
    sl = $urandom_range(1, 8000);
    sh = sl + $urandom_range(0, 4000);
    ll = sh + 1 + $urandom_range(0, 4000);
    lh = ll + $urandom_range(0, 20000);
    pre = 8'($urandom);
    pre[6] = ~pre[7];
    load_config(sl, sh, ll, lh, pre);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed edges under reset windows
    for (int i = 0; i < 27; i++) send_edge(DIRECTED_EDGES[i][15:0], DIRECTED_EDGES[i][16]);

    run_frames(60);

    // narrow windows
    load_config(100, 200, 300, 450, 8'h96);
    run_frames(50);
    // windows at the low and high ends
    load_config(0, 1, 2, 65534, 8'h7F);
    run_frames(50);
    // overlapping windows
    load_config(500, 1500, 1000, 2500, 8'h55);
    run_frames(50);
    // empty short window, preamble that cannot start a frame
    load_config(65535, 0, 1750, 2250, 8'hFF);
    run_frames(25);
    random_config();
    run_frames(40);
    random_config();
    run_frames(40);
    load_config(750, 1250, 1750, 2250, 8'hAA);
    run_frames(35);

    drain();
    if (sb.pending() != 0) sb.report("results never arrived", 0, sb.pending());
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### sim.f
src/mefr_pkg.sv
src/mefr_line.sv
src/mefr_frame.sv
src/manchester_edge_frame_receiver.sv
bench/tb.sv
